### rtl/hss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_pkg
// Types, codes and constants shared by the handrail speed supervisor modules.
// ----------------------------------------------------------------------------
package hss_pkg;

   localparam int WINDOW_LEN_DEF = 4;

   localparam int SUM_W   = 16;
   localparam int SCALE_W = 32;
   localparam int STOP_W  = 14;
   localparam int CSR_W   = 3;
   localparam int DIV_STEPS = 16;

   localparam logic [SUM_W-1:0]  SUM_MAX         = 16'hFFFF;
   localparam logic [SUM_W-1:0]  FAULT_TICKS_RST = 16'd1000;
   localparam logic [STOP_W-1:0] STOP_PERIOD_MIN = 14'd200;
   localparam logic [STOP_W-1:0] STOP_PERIOD_CAP = 14'd10000;

   // machine state codes
   localparam logic [1:0] ESC_READY    = 2'd0;
   localparam logic [1:0] ESC_RUN      = 2'd1;
   localparam logic [1:0] ESC_STOPPING = 2'd2;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_MIN_SUM     = 3'd0;
   localparam logic [CSR_W-1:0] CSR_MAX_SUM     = 3'd1;
   localparam logic [CSR_W-1:0] CSR_SPEED_SCALE = 3'd2;
   localparam logic [CSR_W-1:0] CSR_FAULT_TICKS = 3'd3;
   localparam logic [CSR_W-1:0] CSR_NORMAL_MODE = 3'd4;

   // sticky flag bit positions
   localparam int FLAG_WARN    = 0;
   localparam int FLAG_STUCK   = 1;
   localparam int FLAG_SPEED   = 2;
   localparam int FLAG_STOPPED = 3;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_STUCK = 2'd1,
      KIND_SLOW  = 2'd2,
      KIND_FAST  = 2'd3
   } kind_type;

   typedef struct packed {
      logic               start;
      logic [SCALE_W-1:0] dividend;
      logic [SUM_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/hss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_div
// Radix-2 restoring divider, 32 by 16 bits, with the quotient saturated to
// 16 bits. A zero divisor or an overflowing quotient yields all ones at once.
// ----------------------------------------------------------------------------
module hss_div import hss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [SUM_W-1:0] dsr_ff, dsr_in;
   logic [SUM_W:0]   trial;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         dsr_in = div_req.divisor;
         cnt_in = '0;
         if (div_req.dividend[SCALE_W-1:SUM_W] >= div_req.divisor) begin
            // quotient would not fit, or divisor is zero: saturate
            quo_in  = SUM_MAX;
            busy_in = 1'b0;
         end else begin
            rem_in  = div_req.dividend[SCALE_W-1:SUM_W];
            quo_in  = div_req.dividend[SUM_W-1:0];
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = SUM_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SUM_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### rtl/handrail_speed_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handrail_speed_supervisor
// Handrail speed and stopped-pulse supervision for one handrail channel.
// ----------------------------------------------------------------------------
// One request transaction per supervision tick, one response transaction per
// request. A stopped tick passes the prepare and done steps on its way to the
// response register; a running tick passes prepare, a summing step per window
// entry, evaluate, fault and done, the window being summed one entry a cycle
// through a single saturating adder; a running tick with a rising sensor edge
// also waits on the divider, one quotient bit a cycle, bar a saturated quotient.
// The next request is taken as soon as the sequencer is back in idle, even
// while a response still waits to be taken. Configuration writes are always
// accepted and are to be made only while the block is idle.
// ----------------------------------------------------------------------------
module handrail_speed_supervisor import hss_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_index,
   input  logic [SCALE_W-1:0] csr_wdata,
   // tick requests
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_esc_state,
   input  logic               req_sensor_level,
   input  logic [7:0]         req_motor_pulses,
   // responses
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SUM_W-1:0]   rsp_motor_pulse_sum,
   output logic [SUM_W-1:0]   rsp_speed_hz_x100,
   output logic               rsp_warning,
   output logic               rsp_stuck_fault,
   output logic               rsp_speed_fault,
   output logic               rsp_stopped_pulse_fault
);

   localparam int IDX_W = $clog2(WINDOW_LEN);
   localparam int CNT_W = $clog2(WINDOW_LEN + 2);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_LEN);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PREP  = 7'b0000010,
      ST_SUM   = 7'b0000100,
      ST_EVAL  = 7'b0001000,
      ST_FAULT = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // captured request
   logic [1:0] esc_ff, esc_in;
   logic       level_ff, level_in;
   logic [7:0] pulses_ff, pulses_in;

   // configuration
   logic [SUM_W-1:0]   min_sum_ff, min_sum_in;
   logic [SUM_W-1:0]   max_sum_ff, max_sum_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [SUM_W-1:0]   fault_ticks_ff, fault_ticks_in;
   logic               normal_ff, normal_in;

   // supervision state
   logic               prev_level_ff, prev_level_in;
   logic               was_running_ff, was_running_in;
   logic [STOP_W-1:0]  stop_period_ff, stop_period_in;
   logic [CNT_W-1:0]   edge_count_ff, edge_count_in;
   logic [SUM_W-1:0]   window_ff [WINDOW_LEN];
   logic [SUM_W-1:0]   window_in [WINDOW_LEN];
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [SUM_W-1:0]   window_sum_ff, window_sum_in;
   logic [SUM_W-1:0]   fault_timer_ff, fault_timer_in;
   logic [SUM_W-1:0]   rep_sum_ff, rep_sum_in;
   logic [SUM_W-1:0]   rep_speed_ff, rep_speed_in;
   logic [3:0]         flags_ff, flags_in;

   // sequencer working registers
   logic               edge_ff, edge_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   kind_type           kind_ff, kind_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   out_sum_ff, out_sum_in;
   logic [SUM_W-1:0]   out_speed_ff, out_speed_in;
   logic [3:0]         out_flags_ff, out_flags_in;

   // shared saturating adder
   logic [SUM_W-1:0]   add_a, add_b, add_sat;
   logic [SUM_W:0]     add_raw;

   logic               edge_raw, enter_run, tick_edge, running;
   logic [SUM_W-1:0]   acc_base, operand, ws, ss, timer_next;
   logic [STOP_W-1:0]  stop_next;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   hss_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign edge_raw  = !prev_level_ff && level_ff;
   assign enter_run = (esc_ff == ESC_RUN) && !was_running_ff;
   assign tick_edge = edge_raw && !enter_run;
   assign running   = (esc_ff == ESC_RUN) || (esc_ff == ESC_STOPPING);
   assign acc_base  = enter_run ? '0 : acc_ff;

   // last step of a tick without an edge folds in the running accumulator
   assign operand = (idx_ff == IDX_LAST && !edge_ff) ? acc_ff : window_ff[idx_ff];

   always_comb begin
      if (state_ff == ST_PREP) begin
         add_a = acc_base;
         add_b = {8'd0, pulses_ff};
      end else begin
         add_a = sum_ff;
         add_b = operand;
      end
   end

   assign add_raw = {1'b0, add_a} + {1'b0, add_b};
   assign add_sat = add_raw[SUM_W] ? SUM_MAX : add_raw[SUM_W-1:0];

   assign ws = edge_ff ? sum_ff : window_sum_ff;
   assign ss = edge_ff ? '0 : sum_ff;
   assign timer_next = (fault_timer_ff < SUM_MAX) ? fault_timer_ff + 1'b1 : fault_timer_ff;
   assign stop_next  = (stop_period_ff < STOP_PERIOD_CAP) ? stop_period_ff + 1'b1
                                                           : stop_period_ff;

   assign div_req.start    = (state_ff == ST_EVAL) && edge_ff;
   assign div_req.dividend = scale_ff;
   assign div_req.divisor  = sum_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      esc_in         = esc_ff;
      level_in       = level_ff;
      pulses_in      = pulses_ff;
      min_sum_in     = min_sum_ff;
      max_sum_in     = max_sum_ff;
      scale_in       = scale_ff;
      fault_ticks_in = fault_ticks_ff;
      normal_in      = normal_ff;
      prev_level_in  = prev_level_ff;
      was_running_in = was_running_ff;
      stop_period_in = stop_period_ff;
      edge_count_in  = edge_count_ff;
      window_in      = window_ff;
      acc_in         = acc_ff;
      window_sum_in  = window_sum_ff;
      fault_timer_in = fault_timer_ff;
      rep_sum_in     = rep_sum_ff;
      rep_speed_in   = rep_speed_ff;
      flags_in       = flags_ff;
      edge_in        = edge_ff;
      idx_in         = idx_ff;
      sum_in         = sum_ff;
      kind_in        = kind_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_sum_in     = out_sum_ff;
      out_speed_in   = out_speed_ff;
      out_flags_in   = out_flags_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_MIN_SUM:     min_sum_in     = csr_wdata[SUM_W-1:0];
            CSR_MAX_SUM:     max_sum_in     = csr_wdata[SUM_W-1:0];
            CSR_SPEED_SCALE: scale_in       = csr_wdata;
            CSR_FAULT_TICKS: fault_ticks_in = csr_wdata[SUM_W-1:0];
            CSR_NORMAL_MODE: normal_in      = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               esc_in    = req_esc_state;
               level_in  = req_sensor_level;
               pulses_in = req_motor_pulses;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            prev_level_in  = level_ff;
            was_running_in = (esc_ff == ESC_RUN);
            if (enter_run) begin
               fault_timer_in = '0;
               window_sum_in  = '0;
            end
            if (running) begin
               stop_period_in = STOP_PERIOD_MIN;
               if (tick_edge) begin
                  if (edge_count_ff <= CNT_FULL) begin
                     edge_count_in = edge_count_ff + 1'b1;
                  end
                  for (int i = WINDOW_LEN - 1; i > 0; i--) begin
                     window_in[i] = window_ff[i-1];
                  end
                  window_in[0] = add_sat;
                  acc_in       = '0;
               end else begin
                  acc_in = add_sat;
               end
               edge_in  = tick_edge;
               idx_in   = '0;
               sum_in   = '0;
               state_in = ST_SUM;
            end else begin
               acc_in        = add_sat;
               edge_count_in = '0;
               for (int i = 0; i < WINDOW_LEN; i++) begin
                  window_in[i] = '0;
               end
               stop_period_in = stop_next;
               if (tick_edge) begin
                  if (stop_next < STOP_PERIOD_MIN) begin
                     if (!normal_ff) begin
                        flags_in[FLAG_WARN] = 1'b1;
                     end else begin
                        flags_in[FLAG_STOPPED] = 1'b1;
                     end
                  end else begin
                     stop_period_in = '0;
                  end
               end
               rep_sum_in   = '0;
               rep_speed_in = '0;
               state_in     = ST_DONE;
            end
         end
         ST_SUM: begin
            sum_in = add_sat;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (edge_ff) begin
               window_sum_in = sum_ff;
               rep_sum_in    = sum_ff;
            end
            if (edge_count_ff > CNT_FULL && ws < min_sum_ff) begin
               kind_in = KIND_FAST;
            end else if (ss >= max_sum_ff) begin
               kind_in = KIND_STUCK;
            end else if (ws >= max_sum_ff) begin
               kind_in = KIND_SLOW;
            end else begin
               kind_in = KIND_NONE;
            end
            state_in = ST_FAULT;
         end
         ST_FAULT: begin
            if (kind_ff == KIND_NONE) begin
               fault_timer_in = '0;
            end else begin
               fault_timer_in = timer_next;
               if (timer_next >= fault_ticks_ff) begin
                  if (!normal_ff) begin
                     flags_in[FLAG_WARN] = 1'b1;
                  end else if (kind_ff == KIND_STUCK) begin
                     flags_in[FLAG_STUCK] = 1'b1;
                  end else begin
                     flags_in[FLAG_SPEED] = 1'b1;
                  end
               end
            end
            state_in = edge_ff ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            if (!div_rsp.busy) begin
               rep_speed_in = div_rsp.quotient;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_sum_in   = rep_sum_ff;
               out_speed_in = rep_speed_ff;
               out_flags_in = flags_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         min_sum_ff     <= '0;
         max_sum_ff     <= SUM_MAX;
         scale_ff       <= '0;
         fault_ticks_ff <= FAULT_TICKS_RST;
         normal_ff      <= 1'b1;
         prev_level_ff  <= 1'b1;
         was_running_ff <= 1'b0;
         stop_period_ff <= STOP_PERIOD_MIN;
         edge_count_ff  <= '0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
         acc_ff         <= '0;
         window_sum_ff  <= '0;
         fault_timer_ff <= '0;
         rep_sum_ff     <= '0;
         rep_speed_ff   <= '0;
         flags_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         min_sum_ff     <= min_sum_in;
         max_sum_ff     <= max_sum_in;
         scale_ff       <= scale_in;
         fault_ticks_ff <= fault_ticks_in;
         normal_ff      <= normal_in;
         prev_level_ff  <= prev_level_in;
         was_running_ff <= was_running_in;
         stop_period_ff <= stop_period_in;
         edge_count_ff  <= edge_count_in;
         window_ff      <= window_in;
         acc_ff         <= acc_in;
         window_sum_ff  <= window_sum_in;
         fault_timer_ff <= fault_timer_in;
         rep_sum_ff     <= rep_sum_in;
         rep_speed_ff   <= rep_speed_in;
         flags_ff       <= flags_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      esc_ff       <= esc_in;
      level_ff     <= level_in;
      pulses_ff    <= pulses_in;
      edge_ff      <= edge_in;
      idx_ff       <= idx_in;
      sum_ff       <= sum_in;
      kind_ff      <= kind_in;
      out_sum_ff   <= out_sum_in;
      out_speed_ff <= out_speed_in;
      out_flags_ff <= out_flags_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_motor_pulse_sum     = out_sum_ff;
   assign rsp_speed_hz_x100       = out_speed_ff;
   assign rsp_warning             = out_flags_ff[FLAG_WARN];
   assign rsp_stuck_fault         = out_flags_ff[FLAG_STUCK];
   assign rsp_speed_fault         = out_flags_ff[FLAG_SPEED];
   assign rsp_stopped_pulse_fault = out_flags_ff[FLAG_STOPPED];

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done step");

   a_div_only_on_edge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> edge_ff)
      else $error("divider wait without a sensor edge");

   a_flags_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (($past(flags_ff) & ~flags_ff) == 4'b0000))
      else $error("sticky flag cleared");

   a_zero_sum_speed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && rep_sum_ff == '0) |->
         (rep_speed_ff == '0 || rep_speed_ff == SUM_MAX))
      else $error("speed inconsistent with zero window sum");

   a_edge_count_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP) |=> (edge_count_ff <= CNT_FULL + 1'b1))
      else $error("edge count past its cap");

endmodule

### sim/tb_handrail_speed_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handrail_speed_supervisor
// Self-checking bench for the handrail speed supervisor: a queue-fed driver
// sends tick transactions with random gaps, a monitor predicts every response
// from its own copy of the supervisor state and checks it field by field,
// while the response side stalls at random. Register settings change between
// phases, with the block idle.
// ----------------------------------------------------------------------------
module tb_handrail_speed_supervisor;
   import hss_pkg::*;

   localparam int WINDOW = WINDOW_LEN_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS = 50;
   localparam logic [1:0] ESC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] esc_state;
      logic       sensor_level;
      logic [7:0] motor_pulses;
   } tick_item_type;

   typedef struct packed {
      logic [SUM_W-1:0] pulse_sum;
      logic [SUM_W-1:0] speed;
      logic             warning;
      logic             stuck;
      logic             speed_fault;
      logic             stopped;
   } tick_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_index = '0;
   logic [SCALE_W-1:0] csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_esc_state = ESC_READY;
   logic               req_sensor_level = 1'b0;
   logic [7:0]         req_motor_pulses = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [SUM_W-1:0]   rsp_motor_pulse_sum;
   logic [SUM_W-1:0]   rsp_speed_hz_x100;
   logic               rsp_warning;
   logic               rsp_stuck_fault;
   logic               rsp_speed_fault;
   logic               rsp_stopped_pulse_fault;

   handrail_speed_supervisor #(.WINDOW_LEN(WINDOW)) dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_esc_state          (req_esc_state),
      .req_sensor_level       (req_sensor_level),
      .req_motor_pulses       (req_motor_pulses),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_motor_pulse_sum    (rsp_motor_pulse_sum),
      .rsp_speed_hz_x100      (rsp_speed_hz_x100),
      .rsp_warning            (rsp_warning),
      .rsp_stuck_fault        (rsp_stuck_fault),
      .rsp_speed_fault        (rsp_speed_fault),
      .rsp_stopped_pulse_fault(rsp_stopped_pulse_fault)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Supervisor state as the block should hold it
   // ------------------------------------------------------------------------
   logic [SUM_W-1:0]   cfg_min     = '0;
   logic [SUM_W-1:0]   cfg_max     = SUM_MAX;
   logic [SCALE_W-1:0] cfg_scale   = '0;
   logic [SUM_W-1:0]   cfg_fticks  = FAULT_TICKS_RST;
   logic               cfg_normal  = 1'b1;

   logic               hr_prev_level  = 1'b1;
   logic               hr_was_running = 1'b0;
   logic [STOP_W-1:0]  hr_stop_ticks  = STOP_PERIOD_MIN;
   int                 hr_edges       = 0;
   logic [SUM_W-1:0]   hr_window [WINDOW] = '{default: '0};
   logic [SUM_W-1:0]   hr_accum       = '0;
   logic [SUM_W-1:0]   hr_wsum        = '0;
   logic [SUM_W-1:0]   hr_timer       = '0;
   logic [SUM_W-1:0]   hr_sum_out     = '0;
   logic [SUM_W-1:0]   hr_speed_out   = '0;
   logic [3:0]         hr_flags       = '0;

   tick_item_type   tick_queue[$];
   tick_result_type expected_results[$];

   int  mismatches = 0;
   int  results_checked = 0;
   int  ticks_queued = 0;
   int  run_edges = 0;
   int  settings_used = 0;
   int  idle_cycles = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   bit  req_gaps_on = 1'b0;
   bit  rsp_stalls_on = 1'b0;
   logic req_taken = 1'b0;
   logic gen_level = 1'b0;
   tick_item_type   next_tick;
   tick_result_type predicted, observed, oldest;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic apply_csr(input logic [CSR_W-1:0] idx, input logic [SCALE_W-1:0] data);
      case (idx)
         CSR_MIN_SUM:     cfg_min = data[SUM_W-1:0];
         CSR_MAX_SUM:     cfg_max = data[SUM_W-1:0];
         CSR_SPEED_SCALE: cfg_scale = data;
         CSR_FAULT_TICKS: cfg_fticks = data[SUM_W-1:0];
         CSR_NORMAL_MODE: cfg_normal = data[0];
         default: ;
      endcase
   endtask

   task automatic advance_tick(input logic [1:0] st, input logic lvl,
                               input logic [7:0] pulses, output tick_result_type res);
      logic             edge_seen;
      logic [SUM_W-1:0] stuck_sum;
      logic [SCALE_W-1:0] quot;
      kind_type         kind;
      edge_seen = !hr_prev_level && lvl;
      hr_prev_level = lvl;
      // entering run: restart the measurement and drop an edge on this tick
      if (st == ESC_RUN && !hr_was_running) begin
         hr_accum = '0;
         hr_timer = '0;
         hr_wsum = '0;
         edge_seen = 1'b0;
      end
      hr_accum = sat_add(hr_accum, {8'd0, pulses});
      if (st == ESC_RUN || st == ESC_STOPPING) begin
         stuck_sum = '0;
         kind = KIND_NONE;
         hr_stop_ticks = STOP_PERIOD_MIN;
         if (edge_seen) begin
            if (hr_edges <= WINDOW) hr_edges++;
            for (int i = WINDOW - 1; i > 0; i--) hr_window[i] = hr_window[i-1];
            hr_window[0] = hr_accum;
            hr_accum = '0;
            hr_wsum = '0;
            foreach (hr_window[i]) hr_wsum = sat_add(hr_wsum, hr_window[i]);
            hr_sum_out = hr_wsum;
            quot = cfg_scale / {16'd0, hr_wsum};
            if (hr_wsum == '0 || quot > {16'd0, SUM_MAX}) hr_speed_out = SUM_MAX;
            else hr_speed_out = quot[SUM_W-1:0];
            run_edges++;
         end else begin
            for (int i = 0; i < WINDOW - 1; i++) stuck_sum = sat_add(stuck_sum, hr_window[i]);
            stuck_sum = sat_add(stuck_sum, hr_accum);
         end
         if (hr_edges > WINDOW && hr_wsum < cfg_min) kind = KIND_FAST;
         else if (stuck_sum >= cfg_max) kind = KIND_STUCK;
         else if (hr_wsum >= cfg_max) kind = KIND_SLOW;
         else hr_timer = '0;
         if (kind != KIND_NONE) begin
            if (hr_timer != SUM_MAX) hr_timer++;
            if (hr_timer >= cfg_fticks) begin
               if (!cfg_normal) hr_flags[FLAG_WARN] = 1'b1;
               else if (kind == KIND_STUCK) hr_flags[FLAG_STUCK] = 1'b1;
               else hr_flags[FLAG_SPEED] = 1'b1;
            end
         end
      end else begin
         hr_edges = 0;
         foreach (hr_window[i]) hr_window[i] = '0;
         if (hr_stop_ticks < STOP_PERIOD_CAP) hr_stop_ticks++;
         if (edge_seen) begin
            if (hr_stop_ticks < STOP_PERIOD_MIN) begin
               if (!cfg_normal) hr_flags[FLAG_WARN] = 1'b1;
               else hr_flags[FLAG_STOPPED] = 1'b1;
            end else begin
               hr_stop_ticks = '0;
            end
         end
         hr_sum_out = '0;
         hr_speed_out = '0;
      end
      hr_was_running = (st == ESC_RUN);
      res = {hr_sum_out, hr_speed_out, hr_flags[FLAG_WARN], hr_flags[FLAG_STUCK],
             hr_flags[FLAG_SPEED], hr_flags[FLAG_STOPPED]};
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t ns: response %0d %s expected %0d, got %0d",
                     $time, results_checked, name, want, got);
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver, response stalls and monitor
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      // hold the current transaction until it has been taken
      if (!reset && !(req_valid && !req_taken)) begin
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (tick_queue.size() != 0) begin
            next_tick = tick_queue.pop_front();
            req_esc_state    <= next_tick.esc_state;
            req_sensor_level <= next_tick.sensor_level;
            req_motor_pulses <= next_tick.motor_pulses;
            req_valid        <= 1'b1;
            if (req_gaps_on) req_gap = gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_stalls_on && $urandom_range(0, 2) == 0) rsp_stall = gap_len();
      end
   end

   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            advance_tick(req_esc_state, req_sensor_level, req_motor_pulses, predicted);
            expected_results.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            observed = {rsp_motor_pulse_sum, rsp_speed_hz_x100, rsp_warning,
                        rsp_stuck_fault, rsp_speed_fault, rsp_stopped_pulse_fault};
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t ns: response with no tick outstanding, sum %0d speed %0d",
                        $time, observed.pulse_sum, observed.speed);
            end else begin
               oldest = expected_results.pop_front();
               compare_field("motor_pulse_sum", 32'(oldest.pulse_sum),
                             32'(observed.pulse_sum));
               compare_field("speed_hz_x100", 32'(oldest.speed), 32'(observed.speed));
               compare_field("warning", 32'(oldest.warning), 32'(observed.warning));
               compare_field("stuck_fault", 32'(oldest.stuck), 32'(observed.stuck));
               compare_field("speed_fault", 32'(oldest.speed_fault),
                             32'(observed.speed_fault));
               compare_field("stopped_pulse_fault", 32'(oldest.stopped),
                             32'(observed.stopped));
            end
            results_checked++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles, %0d responses outstanding",
                     $time, IDLE_LIMIT, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic queue_tick(input logic [1:0] st, input logic lvl, input logic [7:0] pulses);
      tick_queue.push_back('{esc_state: st, sensor_level: lvl, motor_pulses: pulses});
      gen_level = lvl;
      ticks_queued++;
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [SCALE_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every tick has been sent and answered, then let the block settle
   task automatic wait_idle();
      do @(posedge clock); while (tick_queue.size() != 0 || req_valid);
      do @(negedge clock); while (expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic start_phase(input logic [SUM_W-1:0] min_sum, input logic [SUM_W-1:0] max_sum,
                              input logic [SCALE_W-1:0] scale, input logic [SUM_W-1:0] fticks,
                              input logic normal);
      if (settings_used != 0) wait_idle();
      req_gaps_on   = ($urandom_range(0, 3) != 0);
      rsp_stalls_on = ($urandom_range(0, 3) != 0);
      write_reg(CSR_MIN_SUM, {16'd0, min_sum});
      write_reg(CSR_MAX_SUM, {16'd0, max_sum});
      write_reg(CSR_SPEED_SCALE, scale);
      write_reg(CSR_FAULT_TICKS, {16'd0, fticks});
      write_reg(CSR_NORMAL_MODE, {31'd0, normal});
      settings_used++;
   endtask

   task automatic queue_directed();
      queue_tick(ESC_UNUSED, 1'b0, 8'd0);
      queue_tick(ESC_READY, 1'b1, 8'd255);     // stopped edge, spacing long enough
      queue_tick(ESC_READY, 1'b0, 8'd0);
      queue_tick(ESC_RUN, 1'b1, 8'd10);        // edge on the entry tick is dropped
      queue_tick(ESC_RUN, 1'b0, 8'd20);
      queue_tick(ESC_RUN, 1'b1, 8'd30);
      queue_tick(ESC_RUN, 1'b0, 8'd0);
      queue_tick(ESC_RUN, 1'b1, 8'd0);
      queue_tick(ESC_READY, 1'b0, 8'd0);
      queue_tick(ESC_RUN, 1'b0, 8'd0);
      queue_tick(ESC_RUN, 1'b1, 8'd0);         // empty window: speed saturates
      for (int i = 0; i < 10; i++) queue_tick(ESC_RUN, logic'(i % 2), 8'd255);
      queue_tick(ESC_STOPPING, 1'b0, 8'd128);
      queue_tick(ESC_STOPPING, 1'b1, 8'd1);
      queue_tick(ESC_READY, 1'b1, 8'd0);
   endtask

   // Stopped-edge spacing at the limit, then a saturated accumulator and window
   task automatic queue_stopped_spacing();
      queue_tick(ESC_STOPPING, 1'b0, 8'd0);
      queue_tick(ESC_READY, 1'b1, 8'd255);
      for (int i = 0; i < 199; i++) queue_tick(ESC_READY, 1'b0, 8'd255);
      queue_tick(ESC_READY, 1'b1, 8'd255);     // spacing exactly at the limit
      for (int i = 0; i < 198; i++) queue_tick(ESC_READY, 1'b0, 8'd255);
      queue_tick(ESC_READY, 1'b1, 8'd255);     // one tick short
      queue_tick(ESC_STOPPING, 1'b0, 8'd255);
      queue_tick(ESC_STOPPING, 1'b1, 8'd255);
      for (int i = 0; i < 3; i++) queue_tick(ESC_STOPPING, 1'b0, 8'd255);
      queue_tick(ESC_STOPPING, 1'b1, 8'd255);
      for (int i = 0; i < 3; i++) queue_tick(ESC_READY, 1'b1, 8'd0);
   endtask

   task automatic queue_noise();
      int n;
      n = $urandom_range(3, 12);
      repeat (n) queue_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)));
   endtask

   // Stopped stretch, a run with a square-wave sensor, then a stopping tail
   task automatic queue_session(input int h_lo, input int h_hi, input int p_lo,
                                input int p_hi, input bit close_stops);
      int         n;
      int         hold;
      logic [1:0] st;
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         st = ($urandom_range(0, 5) == 0) ? ESC_UNUSED : ESC_READY;
         queue_tick(st, (close_stops && k > 0 && $urandom_range(0, 1)) ? !gen_level : gen_level,
                    8'($urandom_range(0, 255)));
      end
      n = $urandom_range(30, 90);
      hold = $urandom_range(h_lo, h_hi);
      for (int k = 0; k < n; k++) begin
         if (hold == 0) begin
            gen_level = !gen_level;
            hold = $urandom_range(h_lo, h_hi);
         end
         hold--;
         st = ($urandom_range(0, 29) == 0) ? 2'($urandom_range(0, 3)) : ESC_RUN;
         queue_tick(st, gen_level, 8'($urandom_range(p_lo, p_hi)));
      end
      n = $urandom_range(0, 5);
      for (int k = 0; k < n; k++)
         queue_tick(ESC_STOPPING, ($urandom_range(0, 2) == 0) ? !gen_level : gen_level,
                    8'($urandom_range(p_lo, p_hi)));
   endtask

   task automatic queue_traffic(input int count, input int h_lo, input int h_hi,
                                input int p_lo, input int p_hi, input bit close_stops);
      int first;
      first = ticks_queued;
      while (ticks_queued - first < count) begin
         if ($urandom_range(0, 9) == 0) queue_noise();
         else queue_session(h_lo, h_hi, p_lo, p_hi, close_stops);
      end
   endtask

   task automatic random_phase();
      logic [SUM_W-1:0]   min_sum, max_sum, fticks;
      logic [SCALE_W-1:0] scale;
      case ($urandom_range(0, 3))
         0: min_sum = '0;
         1: min_sum = SUM_MAX;
         default: min_sum = 16'($urandom_range(0, 4000));
      endcase
      case ($urandom_range(0, 3))
         0: max_sum = '0;
         1: max_sum = SUM_MAX;
         default: max_sum = 16'($urandom_range(1000, 8000));
      endcase
      case ($urandom_range(0, 2))
         0: scale = '0;
         1: scale = '1;
         default: scale = $urandom;
      endcase
      case ($urandom_range(0, 2))
         0: fticks = 16'd1;
         1: fticks = SUM_MAX;
         default: fticks = 16'($urandom_range(1, 100));
      endcase
      start_phase(min_sum, max_sum, scale, fticks, 1'($urandom_range(0, 1)));
      queue_traffic(100, 1, 20, 0, 255, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      start_phase(16'd0, SUM_MAX, 32'hFFFF_FFFF, SUM_MAX, 1'b1);
      queue_directed();
      start_phase(16'd0, SUM_MAX, 32'd1_000_000, 16'd1, 1'b1);
      queue_traffic(120, 2, 12, 0, 255, 1'b0);
      // nominal band around the generated speeds
      start_phase(16'd1000, 16'd4000, 32'd200_000, 16'd50, 1'b1);
      queue_traffic(120, 4, 6, 40, 60, 1'b0);
      start_phase(16'd2000, 16'd3000, $urandom, 16'd5, 1'b0);
      queue_traffic(100, 3, 8, 20, 90, 1'b0);
      start_phase(16'd0, 16'd600, 32'($urandom_range(0, 2_000_000)), 16'd3, 1'b1);
      queue_traffic(100, 2, 10, 0, 255, 1'b0);
      start_phase(SUM_MAX, SUM_MAX, 32'd0, 16'd1, 1'b1);
      queue_traffic(80, 2, 10, 0, 255, 1'b0);
      start_phase(16'd0, SUM_MAX, $urandom, SUM_MAX, 1'b1);
      queue_stopped_spacing();
      queue_traffic(80, 1, 12, 0, 255, 1'b1);
      random_phase();
      random_phase();
      start_phase(16'd0, 16'd0, 32'd0, 16'd1, 1'b0);
      queue_traffic(60, 1, 10, 0, 255, 1'b1);
      wait_idle();

      $display("Checked %0d tick responses over %0d register settings, %0d sensor edges in run",
               results_checked, settings_used, run_edges);
      $display("Sticky flags at the end: warning %0b stuck %0b speed %0b stopped %0b",
               hr_flags[FLAG_WARN], hr_flags[FLAG_STUCK], hr_flags[FLAG_SPEED],
               hr_flags[FLAG_STOPPED]);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
